// ----- design/stt_pkg.sv -----
// Package for the software timer table: item and result types, operation and
// result codes, controller states and the controller/datapath command bundle.
// Depends on nothing; every other file of the block imports it.
package stt_pkg;

  // Table size and the index widths that follow from it.
  localparam int NUM_TIMERS = 32;
  localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CNT_W = $clog2(NUM_TIMERS + 1);

  // Operation codes of an input item.
  localparam logic [1:0] OP_ADD_ONCE     = 2'd0;
  localparam logic [1:0] OP_ADD_PERIODIC = 2'd1;
  localparam logic [1:0] OP_CANCEL       = 2'd2;
  localparam logic [1:0] OP_TICK         = 2'd3;

  // Result kinds.
  localparam logic [2:0] KIND_ADDED     = 3'd0;
  localparam logic [2:0] KIND_REJECTED  = 3'd1;
  localparam logic [2:0] KIND_CANCELLED = 3'd2;
  localparam logic [2:0] KIND_MISSED    = 3'd3;
  localparam logic [2:0] KIND_FIRED     = 3'd4;
  localparam logic [2:0] KIND_TICK_DONE = 3'd5;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] duration_ms;
    logic [31:0] cancel_id;
    logic [15:0] elapsed_ms;
  } stt_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] timer_ident;
    logic        was_periodic;
    logic [31:0] next_due_ms;
    logic        has_next;
    logic        last;
  } stt_result_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_CANCEL,
    S_CANCEL_MISS,
    S_TICK_NOW,
    S_TICK_SCAN,
    S_TICK_DONE
  } stt_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;     // latch the input item
    logic do_add;      // arm the lowest free slot, or reject
    logic scan;        // walk the slot memories, one read a cycle
    logic chk_cancel;  // compare each scanned slot with the cancel id
    logic emit_miss;   // report a cancel that found nothing
    logic now_adv;     // advance the clock and clear the minimum
    logic chk_tick;    // fire due slots and track the earliest deadline
    logic emit_done;   // report the end of a tick
  } stt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic match;       // the slot checked this cycle matched the cancel id
    logic last_chk;    // the last slot is checked this cycle
  } stt_status_t;

endpackage

// ----- design/stt_ctrl.sv -----
// Controller of the software timer table: sequences add, cancel and tick
// operations and drives the datapath through a command bundle.
// Depends on stt_pkg.
module stt_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [1:0]          op,
  output logic                busy,
  output stt_pkg::stt_cmd_t   cmd,
  input  stt_pkg::stt_status_t status
);
  import stt_pkg::*;

  stt_state_t state;
  stt_state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (op) inside
            OP_ADD_ONCE, OP_ADD_PERIODIC: state_next = S_ADD;
            OP_CANCEL:                    state_next = S_CANCEL;
            default:                      state_next = S_TICK_NOW;
          endcase
        end
      end
      S_ADD:         state_next = S_IDLE;
      S_CANCEL: begin
        if (status.match) begin
          state_next = S_IDLE;
        end else if (status.last_chk) begin
          state_next = S_CANCEL_MISS;
        end
      end
      S_CANCEL_MISS: state_next = S_IDLE;
      S_TICK_NOW:    state_next = S_TICK_SCAN;
      S_TICK_SCAN: begin
        if (status.last_chk) begin
          state_next = S_TICK_DONE;
        end
      end
      S_TICK_DONE:   state_next = S_IDLE;
      default:       state_next = S_IDLE;
    endcase
  end

  // Output logic.
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state)
      S_IDLE: begin
        busy        = 1'b0;
        cmd.capture = start;
      end
      S_ADD:         cmd.do_add = 1'b1;
      S_CANCEL: begin
        cmd.scan       = 1'b1;
        cmd.chk_cancel = 1'b1;
      end
      S_CANCEL_MISS: cmd.emit_miss = 1'b1;
      S_TICK_NOW:    cmd.now_adv = 1'b1;
      S_TICK_SCAN: begin
        cmd.scan     = 1'b1;
        cmd.chk_tick = 1'b1;
      end
      S_TICK_DONE:   cmd.emit_done = 1'b1;
      default:       busy = 1'b1;
    endcase
  end

`ifndef NO_ASSERTIONS
  // After its add state, an add returns to idle in the next cycle.
  a_add_one_cycle: assert property (@(posedge clk) disable iff (rst)
    state == S_ADD |=> state == S_IDLE)
    else $error("add did not return to idle");

  // A tick always passes through the clock update before scanning.
  a_tick_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && start && op == OP_TICK) |=> state == S_TICK_NOW)
    else $error("tick did not start with the clock update");
`endif

endmodule

// ----- design/stt_dp.sv -----
// Datapath of the software timer table: slot memories, valid bits, the
// millisecond clock, identifier counter, scan pipeline and result register.
// Depends on stt_pkg.
module stt_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  stt_pkg::stt_item_t   item,
  input  stt_pkg::stt_cmd_t    cmd,
  output stt_pkg::stt_status_t status,
  output logic                 result_valid,
  output stt_pkg::stt_result_t result
);
  import stt_pkg::*;

  stt_item_t                item_q;
  logic [NUM_TIMERS-1:0]    valid;
  logic [NUM_TIMERS-1:0]    periodic;
  logic [31:0]              now_ms;
  logic [31:0]              next_ident;

  logic [31:0]              ident_mem    [NUM_TIMERS];
  logic [31:0]              period_mem   [NUM_TIMERS];
  logic [31:0]              deadline_mem [NUM_TIMERS];

  logic [CNT_W-1:0]         rd_idx;
  logic                     issue;
  logic                     chk_vld;
  logic [IDX_W-1:0]         chk_idx;
  logic [31:0]              rd_ident;
  logic [31:0]              rd_period;
  logic [31:0]              rd_deadline;

  logic [31:0]              best;
  logic                     has;

  logic [IDX_W-1:0]         free_idx;
  logic                     full;
  logic                     slot_v;
  logic                     slot_p;
  logic                     hit;
  logic                     due;
  logic                     fire;
  logic                     remain;
  logic [31:0]              cand;

  logic                     dl_we;
  logic [IDX_W-1:0]         dl_addr;
  logic [31:0]              dl_data;

  stt_result_t              result_next;
  logic                     result_valid_next;

  // Input item latch.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_q <= item;
    end
  end

  // Lowest free slot, searched from the top so the lowest one wins.
  always_comb begin
    free_idx = '0;
    for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        free_idx = IDX_W'(i);
      end
    end
    full = &valid;
  end

  // Scan read address and read issue.
  assign issue = cmd.scan && (rd_idx != CNT_W'(NUM_TIMERS));

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx  <= '0;
      chk_vld <= 1'b0;
    end else begin
      if (!cmd.scan) begin
        rd_idx <= '0;
      end else if (issue) begin
        rd_idx <= rd_idx + CNT_W'(1);
      end
      chk_vld <= issue;
    end
  end

  always_ff @(posedge clk) begin
    chk_idx <= rd_idx[IDX_W-1:0];
  end

  // Check stage: evaluate the slot whose memory words were read last cycle.
  always_comb begin
    slot_v = valid[chk_idx];
    slot_p = periodic[chk_idx];
    hit    = cmd.chk_cancel && chk_vld && slot_v && (rd_ident == item_q.cancel_id);
    due    = rd_deadline <= now_ms;
    fire   = cmd.chk_tick && chk_vld && slot_v && due;
    remain = slot_v && (!due || slot_p);
    cand   = due ? rd_period : (rd_deadline - now_ms);
  end

  assign status.match    = hit;
  assign status.last_chk = chk_vld && (chk_idx == IDX_W'(NUM_TIMERS - 1));

  // Deadline write port: adds arm a new slot, periodic fires re-arm one.
  always_comb begin
    dl_we   = 1'b0;
    dl_addr = free_idx;
    dl_data = now_ms + item_q.duration_ms;
    if (cmd.do_add && !full) begin
      dl_we = 1'b1;
    end else if (fire && slot_p) begin
      dl_we   = 1'b1;
      dl_addr = chk_idx;
      dl_data = now_ms + rd_period;
    end
  end

  // Slot memories, written at one address and read at the scan address.
  always_ff @(posedge clk) begin
    if (cmd.do_add && !full) begin
      ident_mem[free_idx]  <= next_ident;
      period_mem[free_idx] <= item_q.duration_ms;
    end
    if (dl_we) begin
      deadline_mem[dl_addr] <= dl_data;
    end
    if (issue) begin
      rd_ident    <= ident_mem[rd_idx[IDX_W-1:0]];
      rd_period   <= period_mem[rd_idx[IDX_W-1:0]];
      rd_deadline <= deadline_mem[rd_idx[IDX_W-1:0]];
    end
  end

  // Valid and periodic flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      periodic <= '0;
    end else if (cmd.do_add && !full) begin
      valid[free_idx]    <= 1'b1;
      periodic[free_idx] <= item_q.op[0];
    end else if (hit) begin
      valid[chk_idx]    <= 1'b0;
      periodic[chk_idx] <= 1'b0;
    end else if (fire && !slot_p) begin
      valid[chk_idx] <= 1'b0;
    end
  end

  // Millisecond clock and identifier counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      now_ms     <= '0;
      next_ident <= '0;
    end else begin
      if (cmd.now_adv) begin
        now_ms <= now_ms + {16'd0, item_q.elapsed_ms};
      end
      if (cmd.do_add && !full) begin
        next_ident <= next_ident + 32'd1;
      end
    end
  end

  // Running minimum of the delay over slots that stay armed.
  always_ff @(posedge clk) begin
    if (rst) begin
      has  <= 1'b0;
      best <= '1;
    end else if (cmd.now_adv) begin
      has  <= 1'b0;
      best <= '1;
    end else if (cmd.chk_tick && chk_vld && remain) begin
      if (!has || (cand < best)) begin
        best <= cand;
      end
      has <= 1'b1;
    end
  end

  // Result selection: at most one source is active in a cycle.
  always_comb begin
    result_next       = '0;
    result_valid_next = 1'b0;
    if (cmd.do_add) begin
      result_valid_next = 1'b1;
      result_next.last  = 1'b1;
      if (full) begin
        result_next.kind = KIND_REJECTED;
      end else begin
        result_next.kind        = KIND_ADDED;
        result_next.timer_ident = next_ident;
      end
    end else if (hit || cmd.emit_miss) begin
      result_valid_next       = 1'b1;
      result_next.kind        = hit ? KIND_CANCELLED : KIND_MISSED;
      result_next.timer_ident = item_q.cancel_id;
      result_next.last        = 1'b1;
    end else if (fire) begin
      result_valid_next        = 1'b1;
      result_next.kind         = KIND_FIRED;
      result_next.timer_ident  = rd_ident;
      result_next.was_periodic = slot_p;
    end else if (cmd.emit_done) begin
      result_valid_next       = 1'b1;
      result_next.kind        = KIND_TICK_DONE;
      result_next.next_due_ms = has ? best : '1;
      result_next.has_next    = has;
      result_next.last        = 1'b1;
    end
  end

  // Result register: each beat is shown for exactly one cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= result_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

`ifndef NO_ASSERTIONS
  // An accepted add consumes exactly one identifier.
  a_ident_step: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.kind == KIND_ADDED) |->
      next_ident == $past(next_ident) + 32'd1)
    else $error("identifier counter did not advance on add");

  // A successful cancel frees exactly one slot.
  a_cancel_frees: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.kind == KIND_CANCELLED) |->
      $countones(valid) + 1 == $countones($past(valid)))
    else $error("cancel did not free exactly one slot");

  // An add is rejected only when every slot is taken.
  a_reject_full: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.kind == KIND_REJECTED) |-> &valid)
    else $error("add rejected with a free slot");

  // A fired timer is never the closing beat of a tick.
  a_fired_not_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.kind == KIND_FIRED) |-> !result.last)
    else $error("fired beat marked last");
`endif

endmodule

// ----- design/software_timer_table_unit.sv -----
// Top level of the software timer table: joins the controller and datapath.
// Depends on stt_pkg, stt_ctrl and stt_dp.
//
// Usage: an operation item is offered on item with start high; it is taken
// at a rising edge where start is high and busy is low. Operations are add
// one-shot, add periodic, cancel by identifier and tick (advance the clock).
// Each result beat sits on result for exactly one cycle with result_valid
// high; the receiver cannot stall it. The last beat of an item has last set.
// Busy stays high from acceptance until an item is finished, so the block takes
// no new item before it is through with the last one. A cancel stops at the
// first match; a tick scans every slot. The scan reads one slot per cycle
// from the slot memories, so the table size sets the cancel and tick time.
// Each beat appears in the cycle after the datapath produces it, so the final
// beat of an item shows in the first cycle that busy is low again.
// A tick emits one fired beat per due timer, in slot order, then a closing
// beat with the delay to the earliest remaining deadline.
// Reset (synchronous, active high) empties the table and clears the clock
// and the identifier counter; no result is pending after reset.
module software_timer_table_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  stt_pkg::stt_item_t   item,
  output logic                 result_valid,
  output stt_pkg::stt_result_t result
);
  import stt_pkg::*;

  stt_cmd_t    cmd;
  stt_status_t status;

  // Sequencing of each operation.
  stt_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .op     (item.op),
    .busy   (busy),
    .cmd    (cmd),
    .status (status)
  );

  // Slot storage, arithmetic and result beats.
  stt_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule
